/* rtl/core/scsml_pkg.sv */
// Shared constants, types and register codes for the sparse coordinate sorter.
package scsml_pkg;

   // Fixed field layout of one nonzero.
   localparam int FIELD_MODES = 4;
   localparam int FIELD_W     = 32;
   localparam int VALUE_W     = 32;
   localparam int MODE_W      = 2;
   localparam int NM_W        = 3;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_MODES   = 4;
   localparam int DEF_STORE_DEPTH = 64;
   localparam int DEF_COORD_BITS  = 32;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_MODES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_MODE = 1'd1;

   localparam logic [NM_W-1:0]   NUM_MODES_RESET = 3'd3;
   localparam logic [MODE_W-1:0] LAST_MODE_RESET = 2'd0;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // Mode count and trailing mode as they govern one sort.
   typedef struct packed {
      logic [NM_W-1:0]   num_modes;
      logic [MODE_W-1:0] last_mode;
   } sort_cfg_type;

endpackage

/* rtl/core/scsml_if.sv */
// Valid/ready channel interfaces for nonzeros going in and sorted nonzeros coming out.
interface scsml_req_if;
   import scsml_pkg::*;

   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] coord_a;
   logic [FIELD_W-1:0] coord_b;
   logic [FIELD_W-1:0] coord_c;
   logic [FIELD_W-1:0] coord_d;
   logic [VALUE_W-1:0] payload;
   logic               load_last;

   modport source (output valid, coord_a, coord_b, coord_c, coord_d, payload, load_last,
                   input ready);
   modport sink (input valid, coord_a, coord_b, coord_c, coord_d, payload, load_last,
                 output ready);
endinterface

interface scsml_rsp_if;
   import scsml_pkg::*;

   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] out_coord_a;
   logic [FIELD_W-1:0] out_coord_b;
   logic [FIELD_W-1:0] out_coord_c;
   logic [FIELD_W-1:0] out_coord_d;
   logic [VALUE_W-1:0] out_payload;
   logic               emit_last;
   logic               overflow;

   modport source (output valid, out_coord_a, out_coord_b, out_coord_c, out_coord_d,
                   out_payload, emit_last, overflow,
                   input ready);
   modport sink (input valid, out_coord_a, out_coord_b, out_coord_c, out_coord_d,
                 out_payload, emit_last, overflow,
                 output ready);
endinterface

/* rtl/core/scsml_cmp.sv */
// Lexicographic key comparator with one mode moved to the least significant place.
module scsml_cmp #(
   parameter int COORD_BITS = scsml_pkg::DEF_COORD_BITS
) (
   input  logic [scsml_pkg::FIELD_MODES-1:0][COORD_BITS-1:0] lhs,
   input  logic [scsml_pkg::FIELD_MODES-1:0][COORD_BITS-1:0] rhs,
   input  scsml_pkg::sort_cfg_type                           cfg,
   output logic                                              lhs_less
);
   import scsml_pkg::*;

   logic [FIELD_MODES-1:0][COORD_BITS-1:0] lhs_key;
   logic [FIELD_MODES-1:0][COORD_BITS-1:0] rhs_key;
   logic [FIELD_MODES-1:0][MODE_W-1:0]     slot_mode;
   logic [FIELD_MODES-1:0]                 slot_used;

   // Slot s (most significant first) holds modes in ascending order with the
   // trailing mode skipped, then the trailing mode; slots past the mode count
   // compare equal.
   always_comb begin
      for (int s = 0; s < FIELD_MODES; s++) begin
         slot_mode[s] = '0;
         slot_used[s] = 1'b0;
         if (NM_W'(s) < cfg.num_modes - NM_W'(1)) begin
            slot_used[s] = 1'b1;
            if (NM_W'(s) < NM_W'(cfg.last_mode)) begin
               slot_mode[s] = MODE_W'(s);
            end else begin
               slot_mode[s] = MODE_W'(s + 1);
            end
         end else if (NM_W'(s) == cfg.num_modes - NM_W'(1)) begin
            slot_used[s] = 1'b1;
            slot_mode[s] = cfg.last_mode;
         end
      end
   end

   always_comb begin
      for (int s = 0; s < FIELD_MODES; s++) begin
         if (slot_used[s]) begin
            lhs_key[FIELD_MODES-1-s] = lhs[slot_mode[s]];
            rhs_key[FIELD_MODES-1-s] = rhs[slot_mode[s]];
         end else begin
            lhs_key[FIELD_MODES-1-s] = '0;
            rhs_key[FIELD_MODES-1-s] = '0;
         end
      end
   end

   assign lhs_less = lhs_key < rhs_key;

endmodule

/* rtl/core/sparse_coord_sort_mode_last_top.sv */
// Top level of the sparse coordinate sorter: load store, selection scan sequencer, output.
//
//   channel   dir  handshake          word
//   req_if    in   valid/ready        four coordinates, payload, load_last
//   rsp_if    out  valid/ready        four coordinates, payload, emit_last, overflow
//   csr_*     in   csr_we             register index and write data, no read-back
//
// Loading accepts one word per cycle. After the word with load_last the block finds
// each result by a full pass over the n stored entries through the single memory
// read port and one shared comparator. req_if.ready is low from the closing word
// until the final result is taken; a stalled rsp_if holds the result and the sequencer.
// Reset clears the control state only; the entry memory is never cleared.
module sparse_coord_sort_mode_last_top #(
   parameter int MAX_MODES   = scsml_pkg::DEF_MAX_MODES,
   parameter int STORE_DEPTH = scsml_pkg::DEF_STORE_DEPTH,
   parameter int COORD_BITS  = scsml_pkg::DEF_COORD_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   scsml_req_if.sink                          req_if,
   scsml_rsp_if.source                        rsp_if,
   input  logic                               csr_we,
   input  logic [scsml_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [scsml_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import scsml_pkg::*;

   localparam int IDX_W   = $clog2(STORE_DEPTH);
   localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
   localparam int ENTRY_W = FIELD_MODES * COORD_BITS + VALUE_W;
   localparam int CAP_INT = (MAX_MODES < FIELD_MODES) ? MAX_MODES : FIELD_MODES;
   localparam logic [NM_W-1:0] MODE_CAP = NM_W'(CAP_INT);

   // Configuration registers.
   logic [NM_W-1:0]   num_modes_ff;
   logic [MODE_W-1:0] last_mode_ff;

   // Sequencer state.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               dropped_ff, dropped_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0]   out_cnt_ff, out_cnt_in;
   logic               q_vld_ff, q_vld_in;
   logic [IDX_W-1:0]   q_idx_ff;
   logic               best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [STORE_DEPTH-1:0] taken_ff, taken_in;
   sort_cfg_type       cfg_ff, cfg_in;
   sort_cfg_type       cfg_eff;

   // Datapath.
   logic [ENTRY_W-1:0] mem [STORE_DEPTH];
   logic [ENTRY_W-1:0] mem_q_ff;
   logic [ENTRY_W-1:0] best_ent_ff;
   logic [ENTRY_W-1:0] wr_entry;
   logic               wr_en;
   logic               rd_en;
   logic               best_upd;
   logic               q_less;
   logic               rsp_acc;
   logic               is_last;
   logic               store_full;
   logic [FIELD_MODES-1:0][COORD_BITS-1:0] q_coords;
   logic [FIELD_MODES-1:0][COORD_BITS-1:0] best_coords;

   assign rsp_acc    = rsp_if.valid && rsp_if.ready;
   assign store_full = fill_ff == CNT_W'(STORE_DEPTH);
   assign is_last    = out_cnt_ff == n_ff - CNT_W'(1);

   assign wr_entry = {req_if.coord_d[COORD_BITS-1:0], req_if.coord_c[COORD_BITS-1:0],
                      req_if.coord_b[COORD_BITS-1:0], req_if.coord_a[COORD_BITS-1:0],
                      req_if.payload};

   for (genvar m = 0; m < FIELD_MODES; m++) begin : g_unpack
      assign q_coords[m]    = mem_q_ff[VALUE_W + m*COORD_BITS +: COORD_BITS];
      assign best_coords[m] = best_ent_ff[VALUE_W + m*COORD_BITS +: COORD_BITS];
   end

   // Register values in force when the closing word arrives, made legal.
   always_comb begin
      if (num_modes_ff == '0) begin
         cfg_eff.num_modes = NM_W'(1);
      end else if (num_modes_ff > MODE_CAP) begin
         cfg_eff.num_modes = MODE_CAP;
      end else begin
         cfg_eff.num_modes = num_modes_ff;
      end
      if (NM_W'(last_mode_ff) < cfg_eff.num_modes) begin
         cfg_eff.last_mode = last_mode_ff;
      end else begin
         cfg_eff.last_mode = MODE_W'(cfg_eff.num_modes - NM_W'(1));
      end
   end

   scsml_cmp #(
      .COORD_BITS(COORD_BITS)
   ) u_cmp (
      .lhs      (q_coords),
      .rhs      (best_coords),
      .cfg      (cfg_ff),
      .lhs_less (q_less)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         num_modes_ff <= NUM_MODES_RESET;
         last_mode_ff <= LAST_MODE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_MODES: num_modes_ff <= csr_wdata[NM_W-1:0];
            CSR_LAST_MODE: last_mode_ff <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         fill_ff     <= '0;
         dropped_ff  <= 1'b0;
         n_ff        <= '0;
         rd_addr_ff  <= '0;
         out_cnt_ff  <= '0;
         q_vld_ff    <= 1'b0;
         best_vld_ff <= 1'b0;
         taken_ff    <= '0;
         cfg_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         dropped_ff  <= dropped_in;
         n_ff        <= n_in;
         rd_addr_ff  <= rd_addr_in;
         out_cnt_ff  <= out_cnt_in;
         q_vld_ff    <= q_vld_in;
         best_vld_ff <= best_vld_in;
         taken_ff    <= taken_in;
         cfg_ff      <= cfg_in;
      end
   end

   // Each result is the smallest entry not yet sent; ties keep the lower index
   // because the scan runs upward and replaces only on strictly less.
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      dropped_in  = dropped_ff;
      n_in        = n_ff;
      rd_addr_in  = rd_addr_ff;
      out_cnt_in  = out_cnt_ff;
      q_vld_in    = 1'b0;
      best_vld_in = best_vld_ff;
      taken_in    = taken_ff;
      cfg_in      = cfg_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      best_upd    = 1'b0;
      req_if.ready = 1'b0;
      rsp_if.valid = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               if (store_full) begin
                  dropped_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + CNT_W'(1);
               end
               if (req_if.load_last) begin
                  state_in    = ST_SCAN;
                  n_in        = fill_in;
                  rd_addr_in  = '0;
                  out_cnt_in  = '0;
                  best_vld_in = 1'b0;
                  cfg_in      = cfg_eff;
               end
            end
         end
         ST_SCAN: begin
            rd_en = rd_addr_ff != n_ff;
            if (rd_en) begin
               rd_addr_in = rd_addr_ff + CNT_W'(1);
            end
            q_vld_in = rd_en;
            if (q_vld_ff && !taken_ff[q_idx_ff] && (!best_vld_ff || q_less)) begin
               best_upd    = 1'b1;
               best_vld_in = 1'b1;
            end
            if (!rd_en && !q_vld_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_if.valid = 1'b1;
            if (rsp_if.ready) begin
               taken_in[best_idx_ff] = 1'b1;
               out_cnt_in = out_cnt_ff + CNT_W'(1);
               if (is_last) begin
                  state_in   = ST_LOAD;
                  fill_in    = '0;
                  dropped_in = 1'b0;
                  taken_in   = '0;
               end else begin
                  state_in    = ST_SCAN;
                  rd_addr_in  = '0;
                  best_vld_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[fill_ff[IDX_W-1:0]] <= wr_entry;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      q_idx_ff <= rd_addr_ff[IDX_W-1:0];
      if (best_upd) begin
         best_ent_ff <= mem_q_ff;
         best_idx_ff <= q_idx_ff;
      end
   end

   assign rsp_if.out_coord_a = FIELD_W'(best_coords[0]);
   assign rsp_if.out_coord_b = FIELD_W'(best_coords[1]);
   assign rsp_if.out_coord_c = FIELD_W'(best_coords[2]);
   assign rsp_if.out_coord_d = FIELD_W'(best_coords[3]);
   assign rsp_if.out_payload = best_ent_ff[VALUE_W-1:0];
   assign rsp_if.emit_last   = is_last;
   assign rsp_if.overflow    = dropped_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(STORE_DEPTH))
      else $error("fill count beyond store depth");

   a_emit_has_best: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> best_vld_ff)
      else $error("result offered without a selected entry");

   a_taken_count: assert property (@(posedge clock) disable iff (reset)
      $countones(taken_ff) == int'(out_cnt_ff) || state_ff == ST_LOAD)
      else $error("sent-entry marks disagree with result count");

   a_set_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_if.emit_last) |=> (fill_ff == '0 && taken_ff == '0 && !dropped_ff))
      else $error("set state not cleared after final result");

endmodule
